// ===== sv/salc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

   localparam int MAX_SET_BITS = 6;
   localparam int MAX_WAYS     = 8;
   localparam int ADDR_WIDTH   = 64;

   localparam int ADDR_FIELD_BITS = 64;
   localparam int TOTAL_BITS      = 32;
   localparam int NUM_SETS        = 1 << MAX_SET_BITS;
   localparam int NUM_LINES       = NUM_SETS * MAX_WAYS;
   localparam int SET_BITS        = MAX_SET_BITS;
   localparam int WAY_BITS        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_CNT_BITS    = $clog2(MAX_WAYS + 1);
   localparam int SB_BITS         = $clog2(MAX_SET_BITS + 1);
   localparam int AGE_BITS        = WAY_BITS;
   localparam int LINE_BITS       = $clog2(NUM_LINES);
   localparam int TAG_BITS        = ADDR_WIDTH;
   localparam int META_BITS       = MAX_WAYS * (AGE_BITS + 1);

   localparam logic [ADDR_FIELD_BITS-1:0] ADDR_MASK =
      ADDR_FIELD_BITS'((65'd1 << ADDR_WIDTH) - 65'd1);
   localparam logic [AGE_BITS-1:0] AGE_MAX = AGE_BITS'(MAX_WAYS - 1);

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 6;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SET_BITS   = 2'd0,
      CSR_WAYS_USED  = 2'd1,
      CSR_BLOCK_BITS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_STORE  = 2'd1,
      OP_MODIFY = 2'd2,
      OP_IFETCH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      OUT_HIT   = 2'd0,
      OUT_FILL  = 2'd1,
      OUT_EVICT = 2'd2
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      op_type                     op;
      logic [ADDR_FIELD_BITS-1:0] addr;
   } req_word_type;

   typedef struct packed {
      outcome_type           outcome;
      logic                  second_hit;
      logic [TOTAL_BITS-1:0] hit_total;
      logic [TOTAL_BITS-1:0] miss_total;
      logic [TOTAL_BITS-1:0] eviction_total;
   } rsp_word_type;

   typedef struct packed {
      logic [MAX_WAYS-1:0][AGE_BITS-1:0] age;
      logic [MAX_WAYS-1:0]               valid;
   } meta_type;

   function automatic logic [LINE_BITS-1:0] line_index(
      input logic [SET_BITS-1:0] set_idx,
      input logic [WAY_BITS-1:0] way_idx
   );
      return LINE_BITS'(int'(set_idx) * MAX_WAYS + int'(way_idx));
   endfunction

   function automatic logic [SET_BITS-1:0] set_mask(input logic [SB_BITS-1:0] sb);
      logic [SET_BITS:0] one;
      one = (SET_BITS + 1)'(1);
      return SET_BITS'((one << sb) - one);
   endfunction

endpackage

`default_nettype wire

// ===== sv/set_assoc_lru_cache_sim.sv =====
// Channel   Ports                                  Handshake
// request   start, busy, req_word                  taken when start & !busy
// result    rsp_valid, rsp_word                    one-cycle strobe, no stall
// config    csr_valid, csr_ready, csr_index/wdata  taken when valid & ready
//
// A load, store or modify keeps busy high after acceptance while it reads the set's
// metadata row (ST_READ), walks ways 0 to nw - 1 in turn through the shared tag
// compare and victim search (ST_SCAN), where nw is ways_used held to the range 1
// to MAX_WAYS, and writes back (ST_UPDATE). The result strobe follows in the next
// cycle, with busy already low; a new word is taken only once the last is through.
// An instruction fetch is taken without leaving ST_IDLE and gives no result.
// Reset clears the per-set valid flags, so no clearing pass is needed.
// The receiver cannot stall; csr_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_sim (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire salc_pkg::req_word_type               req_word,
   output logic                                      rsp_valid,
   output salc_pkg::rsp_word_type                    rsp_word,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [salc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [salc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   import salc_pkg::*;

   state_type state_ff, state_in;

   logic [2:0] set_bits_ff;
   logic [3:0] ways_used_ff;
   logic [5:0] block_bits_ff;

   op_type                  op_ff;
   logic [SET_BITS-1:0]     set_ff, set_in;
   logic [TAG_BITS-1:0]     tag_ff, tag_in;
   logic [WAY_CNT_BITS-1:0] nw_ff, nw_in;
   logic [WAY_BITS-1:0]     way_ff, cmp_way_ff;

   logic                    hit_found_ff, free_found_ff, victim_found_ff;
   logic [WAY_BITS-1:0]     hit_way_ff, free_way_ff, victim_way_ff;
   logic [AGE_BITS-1:0]     victim_age_ff;

   logic [NUM_SETS-1:0]     row_valid_ff;
   logic [TOTAL_BITS-1:0]   hits_ff, misses_ff, evictions_ff;
   logic [TOTAL_BITS-1:0]   hits_in, misses_in, evictions_in;

   logic                    rsp_valid_ff;
   rsp_word_type            rsp_word_ff, rsp_word_in;

   logic [ADDR_FIELD_BITS-1:0] addr_masked, addr_shifted;
   logic [SB_BITS-1:0]         sb_eff;

   logic [META_BITS-1:0]    meta_rdata;
   meta_type                meta_cur, meta_new;
   logic [TAG_BITS-1:0]     tag_rdata;
   logic                    cur_valid, cur_match;
   logic [AGE_BITS-1:0]     cur_age;
   logic [WAY_BITS-1:0]     target_way;
   logic                    last_way, accept;
   logic                    tag_we;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      addr_masked  = req_word.addr & ADDR_MASK;
      addr_shifted = addr_masked >> block_bits_ff;
      if (int'(set_bits_ff) > MAX_SET_BITS) begin
         sb_eff = SB_BITS'(MAX_SET_BITS);
      end else begin
         sb_eff = SB_BITS'(set_bits_ff);
      end
      set_in = addr_shifted[SET_BITS-1:0] & set_mask(sb_eff);
      tag_in = TAG_BITS'(addr_shifted >> sb_eff);
      if (ways_used_ff == 4'd0) begin
         nw_in = WAY_CNT_BITS'(1);
      end else if (int'(ways_used_ff) > MAX_WAYS) begin
         nw_in = WAY_CNT_BITS'(MAX_WAYS);
      end else begin
         nw_in = WAY_CNT_BITS'(ways_used_ff);
      end
   end

   salc_ram #(
      .WIDTH(META_BITS),
      .DEPTH(NUM_SETS)
   ) u_meta_ram (
      .clock  (clock),
      .wr_en  (state_ff == ST_UPDATE),
      .wr_addr(set_ff),
      .wr_data(meta_new),
      .rd_addr(set_ff),
      .rd_data(meta_rdata)
   );

   salc_ram #(
      .WIDTH(TAG_BITS),
      .DEPTH(NUM_LINES)
   ) u_tag_ram (
      .clock  (clock),
      .wr_en  (tag_we),
      .wr_addr(line_index(set_ff, target_way)),
      .wr_data(tag_ff),
      .rd_addr(line_index(set_ff, way_ff)),
      .rd_data(tag_rdata)
   );

   always_comb begin
      if (row_valid_ff[set_ff]) begin
         meta_cur = meta_type'(meta_rdata);
      end else begin
         meta_cur = '0;
      end
      cur_valid  = meta_cur.valid[cmp_way_ff];
      cur_age    = meta_cur.age[cmp_way_ff];
      cur_match  = (tag_rdata == tag_ff);
      last_way   = (WAY_CNT_BITS'(cmp_way_ff) == nw_ff - WAY_CNT_BITS'(1));
      target_way = free_found_ff ? free_way_ff : victim_way_ff;
      tag_we     = (state_ff == ST_UPDATE) && !hit_found_ff;
   end

   always_comb begin
      logic [AGE_BITS-1:0] hit_age;
      hit_age  = meta_cur.age[hit_way_ff];
      meta_new = meta_cur;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (w < int'(nw_ff) && meta_cur.valid[w]) begin
            if (hit_found_ff) begin
               if (WAY_BITS'(w) != hit_way_ff && meta_cur.age[w] < hit_age &&
                   meta_cur.age[w] < AGE_MAX) begin
                  meta_new.age[w] = meta_cur.age[w] + AGE_BITS'(1);
               end
            end else if (WAY_BITS'(w) != target_way && meta_cur.age[w] < AGE_MAX) begin
               meta_new.age[w] = meta_cur.age[w] + AGE_BITS'(1);
            end
         end
      end
      if (hit_found_ff) begin
         meta_new.age[hit_way_ff] = '0;
      end else begin
         meta_new.age[target_way]   = '0;
         meta_new.valid[target_way] = 1'b1;
      end
   end

   always_comb begin
      hits_in      = hits_ff + TOTAL_BITS'(hit_found_ff) + TOTAL_BITS'(op_ff == OP_MODIFY);
      misses_in    = misses_ff + TOTAL_BITS'(!hit_found_ff);
      evictions_in = evictions_ff + TOTAL_BITS'(!hit_found_ff && !free_found_ff);
      rsp_word_in.second_hit     = (op_ff == OP_MODIFY);
      rsp_word_in.hit_total      = hits_in;
      rsp_word_in.miss_total     = misses_in;
      rsp_word_in.eviction_total = evictions_in;
      if (hit_found_ff) begin
         rsp_word_in.outcome = OUT_HIT;
      end else if (free_found_ff) begin
         rsp_word_in.outcome = OUT_FILL;
      end else begin
         rsp_word_in.outcome = OUT_EVICT;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_word.op != OP_IFETCH) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (last_way) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= 3'd1;
         ways_used_ff  <= 4'd1;
         block_bits_ff <= 6'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SET_BITS:   set_bits_ff   <= csr_wdata[2:0];
            CSR_WAYS_USED:  ways_used_ff  <= csr_wdata[3:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_word.op;
         set_ff <= set_in;
         tag_ff <= tag_in;
         nw_ff  <= nw_in;
      end
      case (state_ff)
         ST_READ: begin
            way_ff     <= way_ff + WAY_BITS'(1);
            cmp_way_ff <= way_ff;
         end
         ST_SCAN: begin
            way_ff     <= way_ff + WAY_BITS'(1);
            cmp_way_ff <= way_ff;
         end
         default: begin
            way_ff <= '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_found_ff    <= 1'b0;
         free_found_ff   <= 1'b0;
         victim_found_ff <= 1'b0;
      end else if (state_ff == ST_READ) begin
         hit_found_ff    <= 1'b0;
         free_found_ff   <= 1'b0;
         victim_found_ff <= 1'b0;
      end else if (state_ff == ST_SCAN) begin
         if (cur_valid) begin
            if (!hit_found_ff && cur_match) begin
               hit_found_ff <= 1'b1;
               hit_way_ff   <= cmp_way_ff;
            end
            if (!victim_found_ff || cur_age >= victim_age_ff) begin
               victim_found_ff <= 1'b1;
               victim_way_ff   <= cmp_way_ff;
               victim_age_ff   <= cur_age;
            end
         end else begin
            free_found_ff <= 1'b1;
            free_way_ff   <= cmp_way_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evictions_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_UPDATE);
         if (state_ff == ST_UPDATE) begin
            row_valid_ff[set_ff] <= 1'b1;
            hits_ff      <= hits_in;
            misses_ff    <= misses_in;
            evictions_ff <= evictions_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ===== sv/salc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
